[rtl/session_sequence_replay_checker_assert.svh]
// Assertion macros for the session sequence replay checker
`ifndef SESSION_SEQUENCE_REPLAY_CHECKER_ASSERT_SVH
`define SESSION_SEQUENCE_REPLAY_CHECKER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SSRC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define SSRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ssrc_pkg.sv]
// Shared types and constants for the session sequence replay checker
`default_nettype none
package ssrc_pkg;

  localparam int RETIRED_DEPTH = 32;
  localparam int COUNT_WIDTH   = 32;
  localparam int STAT_W        = 32;
  localparam int ID_W          = 64;
  localparam int SEQ_W         = 64;
  localparam int SRC_W         = 8;

  typedef enum logic [2:0] {
    REASON_NONE      = 3'd0,
    REASON_DECODE    = 3'd1,
    REASON_SOURCE    = 3'd2,
    REASON_RETIRED   = 3'd3,
    REASON_DUPLICATE = 3'd4,
    REASON_ORDER     = 3'd5
  } reason_t;

  typedef struct packed {
    logic [SEQ_W-1:0] gap;
    reason_t          reason;
    logic             restarted;
  } verdict_t;

endpackage
`default_nettype wire

[rtl/ssrc_ifaces.sv]
// Command and result channel interfaces
`default_nettype none
interface ssrc_cmd_if;
  logic        valid;
  logic        ready;
  logic        decode_ok;
  logic [7:0]  source;
  logic [63:0] sess_id;
  logic [63:0] sequence_req;

  modport src (output valid, decode_ok, source, sess_id, sequence_req, input ready);
  modport snk (input valid, decode_ok, source, sess_id, sequence_req, output ready);
endinterface

interface ssrc_res_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  reject_reason;
  logic        restarted;
  logic [31:0] received_count;
  logic [31:0] accepted_count;
  logic [31:0] rejected_count;
  logic [31:0] restart_count;
  logic [31:0] duplicate_count;
  logic [31:0] out_of_order_count;
  logic [63:0] total_gaps;
  logic [63:0] max_gap;

  modport src (output valid, accepted, reject_reason, restarted, received_count,
               accepted_count, rejected_count, restart_count, duplicate_count,
               out_of_order_count, total_gaps, max_gap, input ready);
  modport snk (input valid, accepted, reject_reason, restarted, received_count,
               accepted_count, rejected_count, restart_count, duplicate_count,
               out_of_order_count, total_gaps, max_gap, output ready);
endinterface
`default_nettype wire

[rtl/ssrc_cell.sv]
// One retired-session slot of the shift chain, with its own compare
`default_nettype none
module ssrc_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic [ssrc_pkg::ID_W-1:0] id_in,
  input  logic                  valid_in,
  input  logic [ssrc_pkg::ID_W-1:0] probe,
  output logic [ssrc_pkg::ID_W-1:0] id_out,
  output logic                  valid_out,
  output logic                  hit
);
  import ssrc_pkg::*;

  logic [ID_W-1:0] id;
  logic            valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      id <= id_in;
    end
  end

  assign id_out    = id;
  assign valid_out = valid;
  assign hit       = valid && (id == probe);

endmodule
`default_nettype wire

[rtl/ssrc_stats.sv]
// Statistics stage: counters, gap accumulation and the result register
`default_nettype none
module ssrc_stats (
  input  logic               clk,
  input  logic               rst,
  input  logic               s1_valid,
  input  ssrc_pkg::verdict_t s1,
  output logic               advance,
  ssrc_res_if.src            res
);
  import ssrc_pkg::*;

  logic                   out_valid;
  logic                   out_accepted;
  reason_t                out_reason;
  logic                   out_restarted;
  logic [COUNT_WIDTH-1:0] cnt_received;
  logic [COUNT_WIDTH-1:0] cnt_accepted;
  logic [COUNT_WIDTH-1:0] cnt_rejected;
  logic [COUNT_WIDTH-1:0] cnt_restart;
  logic [COUNT_WIDTH-1:0] cnt_duplicate;
  logic [COUNT_WIDTH-1:0] cnt_order;
  logic [SEQ_W-1:0]       gap_total;
  logic [SEQ_W-1:0]       gap_largest;
  logic [SEQ_W:0]         gap_sum;
  logic                   load;

  assign advance = !out_valid || res.ready;
  assign load    = s1_valid && advance;
  assign gap_sum = {1'b0, gap_total} + {1'b0, s1.gap};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      cnt_received  <= '0;
      cnt_accepted  <= '0;
      cnt_rejected  <= '0;
      cnt_restart   <= '0;
      cnt_duplicate <= '0;
      cnt_order     <= '0;
      gap_total     <= '0;
      gap_largest   <= '0;
    end else if (load) begin
      out_valid    <= 1'b1;
      cnt_received <= cnt_received + 1'b1;
      if (s1.reason == REASON_NONE) begin
        cnt_accepted <= cnt_accepted + 1'b1;
      end else begin
        cnt_rejected <= cnt_rejected + 1'b1;
      end
      if (s1.restarted) begin
        cnt_restart <= cnt_restart + 1'b1;
      end
      if (s1.reason == REASON_DUPLICATE) begin
        cnt_duplicate <= cnt_duplicate + 1'b1;
      end
      if (s1.reason == REASON_ORDER) begin
        cnt_order <= cnt_order + 1'b1;
      end
      gap_total <= gap_sum[SEQ_W] ? '1 : gap_sum[SEQ_W-1:0];
      if (s1.gap > gap_largest) begin
        gap_largest <= s1.gap;
      end
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_accepted  <= (s1.reason == REASON_NONE);
      out_reason    <= s1.reason;
      out_restarted <= s1.restarted;
    end
  end

  assign res.valid              = out_valid;
  assign res.accepted           = out_accepted;
  assign res.reject_reason      = out_reason;
  assign res.restarted          = out_restarted;
  assign res.received_count     = STAT_W'(cnt_received);
  assign res.accepted_count     = STAT_W'(cnt_accepted);
  assign res.rejected_count     = STAT_W'(cnt_rejected);
  assign res.restart_count      = STAT_W'(cnt_restart);
  assign res.duplicate_count    = STAT_W'(cnt_duplicate);
  assign res.out_of_order_count = STAT_W'(cnt_order);
  assign res.total_gaps         = gap_total;
  assign res.max_gap            = gap_largest;

endmodule
`default_nettype wire

[rtl/session_sequence_replay_checker.sv]
// Top level: command check, session tracking and retired-session shift chain
//
// Usage:
//   cmd: valid/ready channel, one decoded command header per transfer
//        (decode_ok, source, session id, sequence_req).
//   res: valid/ready channel, one result per command: verdict, reject reason,
//        restart flag, running counters and gap statistics after the command.
//   cfg_we/cfg_wdata: writes the expected source code; write only while idle.
//   Throughput: one command per cycle while res is not stalled. The
//   verdict is formed in the accept cycle from a 32-slot shift chain that
//   compares the session id in every slot at once; it is registered in s1,
//   then counters and the saturating gap sum update in the stats stage.
//   Reset: clears the session, sequence tracking, retired slots' valid bits,
//   counters, gap statistics and the expected source; no clearing pass.
//   Receiver stall: the result register holds; one more command is taken
//   into the verdict stage, after which cmd.ready drops until res drains.
`default_nettype none
module session_sequence_replay_checker (
  input  logic       clk,
  input  logic       rst,
  ssrc_cmd_if.snk    cmd,
  ssrc_res_if.src    res,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import ssrc_pkg::*;

  logic [SRC_W-1:0] cfg_source;
  logic [ID_W-1:0]  current_session;
  logic             have_sequence;
  logic [SEQ_W-1:0] previous_sequence;
  logic             s1_valid;
  verdict_t         s1;
  verdict_t         verdict;
  logic             advance;
  logic             accept;
  logic             early;
  logic             change;
  logic             tracking;
  logic             retired_hit;
  logic             shift;

  logic [ID_W-1:0]          chain_id [RETIRED_DEPTH];
  logic [RETIRED_DEPTH-1:0] chain_valid;
  logic [RETIRED_DEPTH-1:0] hits;

  genvar g;
  generate
    for (g = 0; g < RETIRED_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        ssrc_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift    (shift),
          .id_in    (current_session),
          .valid_in (1'b1),
          .probe    (cmd.sess_id),
          .id_out   (chain_id[g]),
          .valid_out(chain_valid[g]),
          .hit      (hits[g])
        );
      end else begin : g_body
        ssrc_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift    (shift),
          .id_in    (chain_id[g-1]),
          .valid_in (chain_valid[g-1]),
          .probe    (cmd.sess_id),
          .id_out   (chain_id[g]),
          .valid_out(chain_valid[g]),
          .hit      (hits[g])
        );
      end
    end
  endgenerate

  assign retired_hit = |hits;
  assign cmd.ready   = !s1_valid || advance;
  assign accept      = cmd.valid && cmd.ready;

  always_comb begin
    early    = !cmd.decode_ok || (cmd.source != cfg_source) || retired_hit;
    change   = (current_session != '0) && (current_session != cmd.sess_id);
    tracking = have_sequence && !change;
    verdict.restarted = !early && change;
    verdict.gap       = '0;
    if (!cmd.decode_ok) begin
      verdict.reason = REASON_DECODE;
    end else if (cmd.source != cfg_source) begin
      verdict.reason = REASON_SOURCE;
    end else if (retired_hit) begin
      verdict.reason = REASON_RETIRED;
    end else if (tracking && cmd.sequence_req == previous_sequence) begin
      verdict.reason = REASON_DUPLICATE;
    end else if (tracking && cmd.sequence_req < previous_sequence) begin
      verdict.reason = REASON_ORDER;
    end else begin
      verdict.reason = REASON_NONE;
      if (tracking) begin
        verdict.gap = cmd.sequence_req - previous_sequence - 1'b1;
      end
    end
  end

  assign shift = accept && verdict.restarted;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_source        <= '0;
      current_session   <= '0;
      have_sequence     <= 1'b0;
      previous_sequence <= '0;
    end else begin
      if (cfg_we) begin
        cfg_source <= cfg_wdata;
      end
      if (accept && !early) begin
        current_session <= cmd.sess_id;
        if (verdict.reason == REASON_NONE) begin
          previous_sequence <= cmd.sequence_req;
          have_sequence     <= 1'b1;
        end else if (verdict.restarted) begin
          have_sequence <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= verdict;
    end
  end

  ssrc_stats u_stats (
    .clk     (clk),
    .rst     (rst),
    .s1_valid(s1_valid),
    .s1      (s1),
    .advance (advance),
    .res     (res)
  );

endmodule
`default_nettype wire

[rtl/ssrc_checker.sv]
// Port-level assertions for the replay checker, bound to the top level
`default_nettype none
`include "session_sequence_replay_checker_assert.svh"
module ssrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_accepted,
  input logic [2:0]  res_reason,
  input logic        res_restarted,
  input logic [63:0] res_total_gaps,
  input logic [63:0] res_max_gap
);
  import ssrc_pkg::*;

  `SSRC_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  `SSRC_ASSERT_IMPL(a_verdict, clk, rst, res_valid, res_accepted == (res_reason == REASON_NONE))
  `SSRC_ASSERT_IMPL(a_restart_accepts, clk, rst, res_valid && res_restarted, res_accepted)
  `SSRC_ASSERT_NEXT(a_gaps_grow, clk, rst, 1'b1,
                    res_total_gaps >= $past(res_total_gaps) && res_max_gap >= $past(res_max_gap))

endmodule

bind session_sequence_replay_checker ssrc_checker u_ssrc_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_accepted  (res.accepted),
  .res_reason    (res.reject_reason),
  .res_restarted (res.restarted),
  .res_total_gaps(res.total_gaps),
  .res_max_gap   (res.max_gap)
);
`default_nettype wire

[sim/session_sequence_replay_checker_test.sv]
// Self-checking testbench for the session sequence replay checker
module session_sequence_replay_checker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1850;
  localparam int POOL_SIZE      = 40;
  localparam int PENDING_DEPTH  = 16;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic        decode_ok;
    logic [7:0]  source;
    logic [63:0] sess_id;
    logic [63:0] sequence_req;
  } header_t;

  typedef struct {
    logic        ok;
    reason_t     reason;
    logic        restarted;
    logic [31:0] received;
    logic [31:0] accepts;
    logic [31:0] rejects;
    logic [31:0] restarts;
    logic [31:0] dups;
    logic [31:0] late;
    logic [63:0] gap_sum;
    logic [63:0] gap_max;
  } verdict_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  ssrc_cmd_if cmd_ch ();
  ssrc_res_if res_ch ();

  session_sequence_replay_checker u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // shadow copy of the checker state
  logic [7:0]  want_source;
  logic [63:0] retired_id [RETIRED_DEPTH];
  logic        retired_live [RETIRED_DEPTH];
  int unsigned retire_slot;
  logic [63:0] live_session;
  logic        seq_seen;
  logic [63:0] last_seq;
  logic [31:0] cnt_received, cnt_accepted, cnt_rejected;
  logic [31:0] cnt_restart, cnt_dup, cnt_late;
  logic [63:0] gap_sum, gap_max;

  // expected results in transfer order
  verdict_row_t pending_rows [PENDING_DEPTH];
  int unsigned  rows_in = 0;
  int unsigned  rows_out = 0;
  int unsigned  error_count = 0;
  int unsigned  results_seen = 0;

  // random traffic generator state
  logic [63:0] sid_pool [POOL_SIZE];
  logic [63:0] gen_sid;
  logic [63:0] gen_seq;

  function automatic void reset_shadow();
    want_source  = '0;
    for (int i = 0; i < RETIRED_DEPTH; i++) begin
      retired_id[i]   = '0;
      retired_live[i] = 1'b0;
    end
    retire_slot  = 0;
    live_session = '0;
    seq_seen     = 1'b0;
    last_seq     = '0;
    cnt_received = '0;
    cnt_accepted = '0;
    cnt_rejected = '0;
    cnt_restart  = '0;
    cnt_dup      = '0;
    cnt_late     = '0;
    gap_sum      = '0;
    gap_max      = '0;
  endfunction

  function automatic logic in_retired(logic [63:0] id);
    for (int i = 0; i < RETIRED_DEPTH; i++)
      if (retired_live[i] && retired_id[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void retire_session(logic [63:0] id);
    if (id == '0 || in_retired(id)) return;
    retired_id[retire_slot]   = id;
    retired_live[retire_slot] = 1'b1;
    retire_slot = (retire_slot + 1) % RETIRED_DEPTH;
  endfunction

  function automatic verdict_row_t judge_header(header_t h);
    verdict_row_t v;
    logic [63:0] gap;
    logic [63:0] room;
    v.reason    = REASON_NONE;
    v.restarted = 1'b0;
    cnt_received++;
    if (!h.decode_ok) begin
      v.reason = REASON_DECODE;
    end else if (h.source != want_source) begin
      v.reason = REASON_SOURCE;
    end else if (in_retired(h.sess_id)) begin
      v.reason = REASON_RETIRED;
    end else begin
      if (live_session != '0 && live_session != h.sess_id) begin
        retire_session(live_session);
        cnt_restart++;
        seq_seen    = 1'b0;
        v.restarted = 1'b1;
      end
      live_session = h.sess_id;
      if (seq_seen && h.sequence_req == last_seq) begin
        v.reason = REASON_DUPLICATE;
        cnt_dup++;
      end else if (seq_seen && h.sequence_req < last_seq) begin
        v.reason = REASON_ORDER;
        cnt_late++;
      end else begin
        if (seq_seen) begin
          gap = h.sequence_req - last_seq - 64'd1;
          if (gap != '0) begin
            room = ~gap_sum;
            gap_sum = gap_sum + ((gap < room) ? gap : room);
            if (gap > gap_max) gap_max = gap;
          end
        end
        last_seq = h.sequence_req;
        seq_seen = 1'b1;
      end
    end
    if (v.reason != REASON_NONE) cnt_rejected++;
    else cnt_accepted++;
    v.ok       = (v.reason == REASON_NONE);
    v.received = cnt_received;
    v.accepts  = cnt_accepted;
    v.rejects  = cnt_rejected;
    v.restarts = cnt_restart;
    v.dups     = cnt_dup;
    v.late     = cnt_late;
    v.gap_sum  = gap_sum;
    v.gap_max  = gap_max;
    return v;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("MISMATCH result %0d: %s", results_seen, what);
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic check_verdict();
    verdict_row_t w;
    results_seen++;
    if (rows_in == rows_out) begin
      report_mismatch("result with no transfer pending");
    end else begin
      w = pending_rows[rows_out % PENDING_DEPTH];
      rows_out++;
      compare_field("accepted", 64'(res_ch.accepted), 64'(w.ok));
      compare_field("reject_reason", 64'(res_ch.reject_reason), 64'(w.reason));
      compare_field("restarted", 64'(res_ch.restarted), 64'(w.restarted));
      compare_field("received_count", 64'(res_ch.received_count), 64'(w.received));
      compare_field("accepted_count", 64'(res_ch.accepted_count), 64'(w.accepts));
      compare_field("rejected_count", 64'(res_ch.rejected_count), 64'(w.rejects));
      compare_field("restart_count", 64'(res_ch.restart_count), 64'(w.restarts));
      compare_field("duplicate_count", 64'(res_ch.duplicate_count), 64'(w.dups));
      compare_field("out_of_order_count", 64'(res_ch.out_of_order_count), 64'(w.late));
      compare_field("total_gaps", res_ch.total_gaps, w.gap_sum);
      compare_field("max_gap", res_ch.max_gap, w.gap_max);
    end
  endtask

  // result side: check, then stall on a repeating pattern that is re-picked now and then
  int unsigned ready_phase = 0;
  int unsigned ready_period = 1;
  int unsigned ready_low = 0;
  int unsigned ready_epoch = 0;

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) check_verdict();
    if (ready_epoch == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        ready_period = 1;
        ready_low    = 0;
      end else begin
        ready_period = $urandom_range(2, 10);
        ready_low    = $urandom_range(1, ready_period - 1);
      end
      ready_epoch = $urandom_range(20, 120);
    end else begin
      ready_epoch--;
    end
    ready_phase = (ready_phase + 1) % ready_period;
    res_ch.ready <= (ready_phase >= ready_low);
  end

  // watchdog: cycles with work outstanding but no transfer on either channel
  initial begin
    int unsigned stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (!cmd_ch.valid && rows_in == rows_out))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_header(header_t h);
    cmd_ch.valid        <= 1'b1;
    cmd_ch.decode_ok    <= h.decode_ok;
    cmd_ch.source       <= h.source;
    cmd_ch.sess_id      <= h.sess_id;
    cmd_ch.sequence_req <= h.sequence_req;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_rows[rows_in % PENDING_DEPTH] = judge_header(h);
    rows_in++;
  endtask

  task automatic send_fields(logic ok, logic [7:0] src, logic [63:0] sid, logic [63:0] seq);
    header_t h;
    h.decode_ok    = ok;
    h.source       = src;
    h.sess_id      = sid;
    h.sequence_req = seq;
    send_header(h);
  endtask

  task automatic pause_idle(int unsigned cycles);
    cmd_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (rows_in != rows_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_source(logic [7:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    want_source = value;
  endtask

  function automatic header_t make_random_header();
    header_t h;
    int unsigned roll;
    roll           = $urandom_range(0, 99);
    h.decode_ok    = 1'b1;
    h.source       = want_source;
    if (roll < 5) begin
      h.decode_ok    = 1'b0;
      h.source       = 8'($urandom);
      h.sess_id      = {$urandom, $urandom};
      h.sequence_req = {$urandom, $urandom};
      return h;
    end
    if (roll < 10) begin
      h.source       = want_source ^ 8'($urandom_range(1, 255));
      h.sess_id      = ($urandom_range(0, 1) == 0) ? gen_sid : {$urandom, $urandom};
      h.sequence_req = {$urandom, $urandom};
      return h;
    end
    h.sess_id = gen_sid;
    if (roll < 18) begin
      gen_sid = sid_pool[$urandom_range(0, POOL_SIZE - 1)];
      gen_seq = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
                64'($urandom_range(0, 3));
      h.sess_id      = gen_sid;
      h.sequence_req = gen_seq;
    end else if (roll < 22) begin
      h.sequence_req = gen_seq;
    end else if (roll < 26) begin
      h.sequence_req = gen_seq - 64'($urandom_range(1, 50));
    end else if (roll < 29) begin
      gen_seq = gen_seq + ({$urandom, $urandom} >> $urandom_range(0, 63));
      h.sequence_req = gen_seq;
    end else if (roll < 37) begin
      gen_seq = gen_seq + 64'($urandom_range(2, 200));
      h.sequence_req = gen_seq;
    end else begin
      gen_seq = gen_seq + 64'd1;
      h.sequence_req = gen_seq;
    end
    return h;
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < count) begin
        send_header(make_random_header());
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) pause_idle($urandom_range(1, 12));
    end
  endtask

  task automatic test_early_rejects();
    write_source(8'h00);
    send_fields(1'b0, 8'hFF, ALL_ONES, ALL_ONES);
    send_fields(1'b0, 8'h00, 64'd0, 64'd0);
    send_fields(1'b1, 8'hFF, 64'd1, 64'd1);
    send_fields(1'b1, 8'h01, 64'd2, 64'd2);
  endtask

  task automatic test_sequence_tracking();
    send_fields(1'b1, 8'h00, 64'd0, 64'd0);
    send_fields(1'b1, 8'h00, 64'd0, 64'd0);
    send_fields(1'b1, 8'h00, 64'd0, 64'd5);
    send_fields(1'b1, 8'h00, 64'd0, 64'd3);
    send_fields(1'b1, 8'h00, 64'd0, 64'd6);
  endtask

  task automatic test_session_restart();
    logic [63:0] sid_a;
    logic [63:0] sid_b;
    sid_a = 64'h8000_0000_0000_0001;
    sid_b = 64'h0000_0000_0000_00B2;
    // leaving session zero is not a restart
    send_fields(1'b1, 8'h00, sid_a, 64'd0);
    send_fields(1'b1, 8'h00, sid_a, 64'd10);
    send_fields(1'b1, 8'h00, sid_b, 64'd1);
    send_fields(1'b1, 8'h00, sid_a, 64'd20);
    send_fields(1'b1, 8'h00, sid_b, 64'd1);
    send_fields(1'b1, 8'h00, 64'd0, 64'd7);
    send_fields(1'b1, 8'h00, sid_b, 64'd9);
  endtask

  task automatic test_gap_saturation();
    logic [63:0] sid_c;
    logic [63:0] sid_d;
    sid_c = 64'h5A5A_5A5A_A5A5_A5A5;
    sid_d = ALL_ONES;
    write_source(8'hFF);
    send_fields(1'b1, 8'hFF, 64'd0, ALL_ONES);
    send_fields(1'b1, 8'hFF, sid_c, 64'd0);
    send_fields(1'b1, 8'hFF, sid_d, 64'd0);
    send_fields(1'b1, 8'hFF, sid_d, 64'h8000_0000_0000_0000);
    send_fields(1'b1, 8'hFF, sid_d, ALL_ONES);
    send_fields(1'b1, 8'hFF, sid_d, ALL_ONES);
  endtask

  task automatic test_random_traffic();
    logic [7:0] settings [4];
    settings[0] = 8'hFF;
    settings[1] = 8'h00;
    settings[2] = 8'($urandom);
    settings[3] = 8'($urandom);
    for (int p = 0; p < 4; p++) begin
      write_source(settings[p]);
      run_random(RANDOM_ITEMS / 4);
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.decode_ok    = 1'b0;
    cmd_ch.source       = '0;
    cmd_ch.sess_id      = '0;
    cmd_ch.sequence_req = '0;
    reset_shadow();
    sid_pool[0] = '0;
    sid_pool[1] = ALL_ONES;
    for (int i = 2; i < POOL_SIZE; i++) sid_pool[i] = {$urandom, $urandom};
    gen_sid = '0;
    gen_seq = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_early_rejects();
    test_sequence_tracking();
    test_session_restart();
    test_gap_saturation();
    test_random_traffic();
    drain_results();
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ssrc_pkg.sv
rtl/ssrc_ifaces.sv
rtl/ssrc_cell.sv
rtl/ssrc_stats.sv
rtl/session_sequence_replay_checker.sv
rtl/ssrc_checker.sv
sim/session_sequence_replay_checker_test.sv
